FILE: hdl/assert_macros.svh
// assertion macros shared by the heap block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

FILE: hdl/kmh_pkg.sv
// package for the keyed max-heap bank: sizes, codes and payload types
// no dependencies
`timescale 1ns / 1ps
package kmh_pkg;
  localparam int NumHeaps = 16;
  localparam int HeapCapacity = 64;
  localparam int HidW = $clog2(NumHeaps);
  localparam int SlotW = $clog2(HeapCapacity);
  localparam int CntW = $clog2(HeapCapacity + 1);
  // slot walker width: child index of the last slot still fits
  localparam int IdxW = CntW + 1;
  localparam int AddrW = HidW + SlotW;
  localparam int Depth = NumHeaps * HeapCapacity;

  typedef enum logic [1:0] {OP_INSERT = 2'd0, OP_DELETE = 2'd1, OP_CHANGE = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_FULL = 2'd1, ST_MISSING = 2'd2,
                            ST_PRESENT = 2'd3} status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [5:0] tag;
  } entry_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] heap_id;
    logic [5:0] tag;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_key;
    logic [5:0] top_tag;
    logic signed [31:0] second_key;
    logic [5:0] second_tag;
    logic second_valid;
    logic [6:0] entry_count;
    logic [1:0] status;
  } rsp_t;
endpackage

FILE: hdl/kmh_if.sv
// valid/ready channel carrying one payload struct
// depends on kmh_pkg
`timescale 1ns / 1ps
interface kmh_req_if (input logic clk);
  import kmh_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmh_rsp_if (input logic clk);
  import kmh_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/kmh_ram.sv
// generic single-port-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module kmh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/keyed_max_heap_by_tag.sv
// keyed max-heap bank top level: sequencer around one entry RAM
// depends on kmh_pkg, kmh_if, kmh_ram, assert_macros.svh
//
// usage: transactions arrive on req (opcode, heap_id, tag, key); one result
// per request leaves on rsp with the heap's top, runner-up, count and status.
// entries of all heaps live in one RAM of 1024 key/tag words with a
// registered read; the 16 heap counts sit in registers.
// one request is worked on at a time. it passes the tag search slot by
// slot, the decision, for a delete the fetch of the last entry, the levels
// of sift-up, the levels of sift-down, the closing of the sift, and the
// reading of the top and its children.
// the longest request is a change of the 64th entry of a full heap that
// rises to the root; the next request can be accepted once the current
// result has entered the output register. the single read port of the
// entry RAM paces these steps.
// reset clears all heap counts; the RAM is not cleared since only data
// from slots within a heap's count is ever used.
// a result waits in an output register until rsp.ready; a request accepted
// meanwhile is worked on and holds in its last step until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyed_max_heap_by_tag (
  input logic clk,
  input logic rst,
  kmh_req_if.sink req,
  kmh_rsp_if.source rsp
);
  import kmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FWAIT, S_DECIDE, S_LAST, S_LOAD, S_UP, S_UPCMP,
    S_UPEND, S_DN, S_DNL, S_DNR, S_TOP, S_TOP2, S_TOP3, S_TOP4
  } state_t;

  state_t state;
  req_t cur;
  logic [CntW-1:0] sizes [NumHeaps];
  logic [IdxW-1:0] n;
  logic [IdxW-1:0] idx;      // 1-based slot being read
  logic [IdxW-1:0] pos;      // 1-based hole of the moving entry
  logic [IdxW-1:0] found;    // 0 when the tag is absent
  logic rose;
  entry_t ent;               // entry being sifted
  entry_t lchild;
  entry_t root;
  status_t status;
  rsp_t out;
  logic out_valid;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  logic [HidW-1:0] hid;
  logic emit;
  logic up_go;
  logic has_r, go_l, go_r, sink_more;
  entry_t best, best_ent;
  logic [IdxW-1:0] best_idx;
  logic pick_r;
  entry_t second;
  rsp_t result;

  function automatic logic [AddrW-1:0] addr_of(logic [HidW-1:0] h, logic [IdxW-1:0] i);
    logic [IdxW-1:0] z;
    z = i - IdxW'(1);
    return {h, z[SlotW-1:0]};
  endfunction

  kmh_ram #(.Width($bits(entry_t)), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign hid = cur.heap_id[HidW-1:0];
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data = out;
  assign raddr = addr_of(hid, idx);
  assign emit = (state == S_TOP4) && (!out_valid || rsp.ready);

  // sift decisions; in S_DNR idx is the right child and lchild the left
  always_comb begin
    up_go = ent.key > rdata.key;
    has_r = idx <= n;
    go_l = lchild.key > ent.key;
    best = go_l ? lchild : ent;
    go_r = has_r && (rdata.key > best.key);
    sink_more = go_l || go_r;
    best_ent = go_r ? rdata : lchild;
    best_idx = go_r ? idx : idx - IdxW'(1);
  end

  // the hole walks; the moving entry is written once at its final slot
  always_comb begin
    we = 1'b0;
    waddr = addr_of(hid, pos);
    wdata = ent;
    unique case (state)
      S_UPCMP: begin
        we = up_go;
        wdata = rdata;
      end
      S_UPEND: we = rose || (op_t'(cur.opcode) == OP_INSERT);
      S_DN: we = idx > n;
      S_DNR: begin
        we = 1'b1;
        wdata = sink_more ? best_ent : ent;
      end
      default: ;
    endcase
  end

  // right child wins a tie for runner-up
  always_comb begin
    pick_r = (n >= IdxW'(3)) && !(lchild.key > rdata.key);
    second = pick_r ? rdata : lchild;
    result.top_key = (n >= IdxW'(1)) ? root.key : '0;
    result.top_tag = (n >= IdxW'(1)) ? root.tag : '0;
    result.second_valid = n >= IdxW'(2);
    result.second_key = (n >= IdxW'(2)) ? second.key : '0;
    result.second_tag = (n >= IdxW'(2)) ? second.tag : '0;
    result.entry_count = n[CntW-1:0];
    result.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      n <= '0;
      for (int i = 0; i < NumHeaps; i++) sizes[i] <= '0;
    end else begin
      if (emit) begin
        out <= result;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          cur <= req.data;
          n <= IdxW'(sizes[req.data.heap_id[HidW-1:0]]);
          idx <= IdxW'(1);
          found <= '0;
          state <= S_FIND;
        end
        S_FIND: begin
          // idx addresses the ram now; data arrives next cycle
          if (op_t'(cur.opcode) == OP_NONE || idx > n) state <= S_DECIDE;
          else state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (rdata.tag == cur.tag) begin
            found <= idx;
            state <= S_DECIDE;
          end else begin
            idx <= idx + IdxW'(1);
            state <= S_FIND;
          end
        end
        S_DECIDE: begin
          rose <= 1'b0;
          unique case (op_t'(cur.opcode))
            OP_INSERT: begin
              if (found != '0) begin
                status <= ST_PRESENT; idx <= IdxW'(1); state <= S_TOP;
              end else if (n >= IdxW'(HeapCapacity)) begin
                status <= ST_FULL; idx <= IdxW'(1); state <= S_TOP;
              end else begin
                status <= ST_OK;
                n <= n + IdxW'(1);
                sizes[hid] <= CntW'(n + IdxW'(1));
                ent <= '{key: cur.key, tag: cur.tag};
                pos <= n + IdxW'(1);
                idx <= (n + IdxW'(1)) >> 1;
                state <= S_UP;
              end
            end
            OP_DELETE: begin
              if (found == '0) begin
                status <= ST_MISSING; idx <= IdxW'(1); state <= S_TOP;
              end else begin
                status <= ST_OK;
                n <= n - IdxW'(1);
                sizes[hid] <= CntW'(n - IdxW'(1));
                pos <= found;
                if (found < n) begin
                  idx <= n; state <= S_LAST;
                end else begin
                  idx <= IdxW'(1); state <= S_TOP;
                end
              end
            end
            OP_CHANGE: begin
              if (found == '0) begin
                status <= ST_MISSING; idx <= IdxW'(1); state <= S_TOP;
              end else begin
                status <= ST_OK;
                ent <= '{key: cur.key, tag: cur.tag};
                pos <= found;
                idx <= found >> 1;
                state <= S_UP;
              end
            end
            OP_NONE: begin
              status <= ST_OK; idx <= IdxW'(1); state <= S_TOP;
            end
          endcase
        end
        S_LAST: state <= S_LOAD;
        S_LOAD: begin
          // last entry fills the hole left by the delete
          ent <= rdata;
          idx <= pos >> 1;
          state <= S_UP;
        end
        S_UP: begin
          if (pos <= IdxW'(1)) state <= S_UPEND;
          else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (up_go) begin
            pos <= pos >> 1;
            rose <= 1'b1;
            idx <= pos >> 2;
            state <= S_UP;
          end else begin
            state <= S_UPEND;
          end
        end
        S_UPEND: begin
          if (rose || op_t'(cur.opcode) == OP_INSERT) begin
            idx <= IdxW'(1); state <= S_TOP;
          end else begin
            idx <= pos << 1; state <= S_DN;
          end
        end
        S_DN: begin
          if (idx > n) begin
            idx <= IdxW'(1); state <= S_TOP;
          end else begin
            idx <= idx + IdxW'(1); state <= S_DNL;
          end
        end
        S_DNL: begin
          lchild <= rdata;
          state <= S_DNR;
        end
        S_DNR: begin
          if (sink_more) begin
            pos <= best_idx;
            idx <= best_idx << 1;
            state <= S_DN;
          end else begin
            idx <= IdxW'(1); state <= S_TOP;
          end
        end
        S_TOP: begin idx <= IdxW'(2); state <= S_TOP2; end
        S_TOP2: begin root <= rdata; idx <= IdxW'(3); state <= S_TOP3; end
        S_TOP3: begin lchild <= rdata; state <= S_TOP4; end
        S_TOP4: if (emit) state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !rsp.ready |=> out_valid, "result dropped")
  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && !rsp.ready |=> $stable(out), "result changed")
  `ASSERT_CLK(a_no_accept_busy, clk, rst, state != S_IDLE |-> !req.ready, "accept while busy")
  `ASSERT_CLK(a_count_range, clk, rst, n <= IdxW'(HeapCapacity), "count over capacity")
  `ASSERT_CLK(a_emit_valid, clk, rst, emit |=> out_valid, "missing result")
endmodule
